FILE: hw/rtl/lifo_pkg.sv
// Shared types and constants for the LIFO stack with duplicate and swap.
package lifo_pkg;

    // Default stack capacity in words
    localparam int DEPTH_DEF   = 64;
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int DEPTH_NOW_W = 7;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Operation codes carried on s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH  = 3'd0,
        FN_POP   = 3'd1,
        FN_SWAP  = 3'd2,
        FN_DUP   = 3'd3,
        FN_PEEK  = 3'd4,
        FN_CLEAR = 3'd5,
        FN_DUMP  = 3'd6,
        FN_NONE  = 3'd7
    } func_t;

    // Result status carried on m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2
    } stat_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_SHIFT_DN = 3'd1,  // take the word from the cell above (push)
        CELL_SHIFT_UP = 3'd2,  // take the word from the cell below (pop)
        CELL_SWAP     = 3'd3,  // top two cells exchange words
        CELL_ROTATE   = 3'd4   // shift up, last occupied cell takes the top
    } cell_cmd_t;

endpackage

FILE: hw/rtl/lifo_cell.sv
// One storage cell of the stack chain; cell 0 holds the top of stack.
module lifo_cell import lifo_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [CW-1:0]     count,
    input  logic [WORD_W-1:0] up_data,
    input  logic [WORD_W-1:0] down_data,
    input  logic [WORD_W-1:0] wrap_data,
    output logic [WORD_W-1:0] data
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              is_end;

    // this cell holds the bottom entry of the occupied region
    assign is_end = (count == CW'(IDX + 1));

    // next word select
    always_comb begin
        data_next = data_reg;
        case (cmd)
            CELL_HOLD:     data_next = data_reg;
            CELL_SHIFT_DN: data_next = up_data;
            CELL_SHIFT_UP: data_next = down_data;
            CELL_SWAP: begin
                if (IDX == 0) begin
                    data_next = down_data;
                end else if (IDX == 1) begin
                    data_next = up_data;
                end
            end
            CELL_ROTATE:   data_next = is_end ? wrap_data : down_data;
            default:       data_next = data_reg;
        endcase
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/lifo_stack_with_dup_swap.sv
// LIFO stack of signed words: push, pop, swap, duplicate, peek, clear, dump.
// A result word is registered in the cycle after its command word is taken.
// Throughput: one command per cycle unless the output stalls; a dump holds input off
// until all its entries are out, rotating one entry to the top per unstalled cycle.
// Reset (aresetn low, synchronous) empties the stack; cell contents are not cleared.
module lifo_stack_with_dup_swap import lifo_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [FUNC_W-1:0]    s_tuser,   // [2:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] result_value, [38:32] depth_now, pad
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                 m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {ST_IDLE, ST_DUMP} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_value_reg, m_value_next;
    stat_t             m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;
    logic [CW-1:0]     m_depth_reg, m_depth_next;

    cell_cmd_t         cmd;
    logic [WORD_W-1:0] push_word;
    logic [WORD_W-1:0] cell_data [DEPTH];
    logic              out_free;
    logic              s_acc;
    func_t             func;
    logic              full;
    logic              empty;

    assign func     = func_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // chain of cells, top at index 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] up_w;
        logic [WORD_W-1:0] dn_w;
        if (i == 0) begin : g_top
            assign up_w = push_word;
        end else begin : g_mid
            assign up_w = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_bot
            assign dn_w = '0;
        end else begin : g_nbot
            assign dn_w = cell_data[i+1];
        end
        lifo_cell #(.IDX(i), .CW(CW)) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .count     (count_reg),
            .up_data   (up_w),
            .down_data (dn_w),
            .wrap_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    // command decode and result generation
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_depth_next  = m_depth_reg;
        cmd           = CELL_HOLD;
        push_word     = s_tdata[WORD_W-1:0];

        if (state_reg == ST_DUMP) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_value_next  = cell_data[0];
                m_status_next = STAT_OK;
                m_last_next   = (remain_reg == CW'(1));
                m_depth_next  = count_reg;
                cmd           = CELL_ROTATE;
                remain_next   = remain_reg - CW'(1);
                if (remain_reg == CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
        end else if (s_acc && func != FN_NONE) begin
            m_valid_next  = 1'b1;
            m_value_next  = '0;
            m_status_next = STAT_OK;
            m_last_next   = 1'b1;
            case (func)
                FN_PUSH: begin
                    if (full) begin
                        m_status_next = STAT_OVER;
                    end else begin
                        cmd        = CELL_SHIFT_DN;
                        count_next = count_reg + CW'(1);
                    end
                end
                FN_POP: begin
                    if (empty) begin
                        m_status_next = STAT_UNDER;
                    end else begin
                        m_value_next = cell_data[0];
                        cmd          = CELL_SHIFT_UP;
                        count_next   = count_reg - CW'(1);
                    end
                end
                FN_SWAP: begin
                    if (count_reg < CW'(2)) begin
                        m_status_next = STAT_UNDER;
                    end else begin
                        cmd = CELL_SWAP;
                    end
                end
                FN_DUP: begin
                    if (empty) begin
                        m_status_next = STAT_UNDER;
                    end else if (full) begin
                        m_status_next = STAT_OVER;
                    end else begin
                        push_word  = cell_data[0];
                        cmd        = CELL_SHIFT_DN;
                        count_next = count_reg + CW'(1);
                    end
                end
                FN_PEEK: begin
                    if (empty) begin
                        m_status_next = STAT_UNDER;
                    end else begin
                        m_value_next = cell_data[0];
                    end
                end
                FN_CLEAR: begin
                    count_next = '0;
                end
                FN_DUMP: begin
                    if (empty) begin
                        m_status_next = STAT_UNDER;
                    end else begin
                        m_value_next = cell_data[0];
                        m_last_next  = (count_reg == CW'(1));
                        cmd          = CELL_ROTATE;
                        remain_next  = count_reg - CW'(1);
                        if (count_reg != CW'(1)) begin
                            state_next = ST_DUMP;
                        end
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_tready;
                end
            endcase
            m_depth_next = count_next;
        end
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - DEPTH_NOW_W){1'b0}},
                       DEPTH_NOW_W'(m_depth_reg), m_value_reg};

    // stack never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // no new command while a dump is still draining
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("input taken during dump");

    // remaining dump words stay below the entry count
    a_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> (remain_reg != '0 && remain_reg < count_reg))
        else $error("dump counter out of range");

    // successful push grows the stack by one
    a_push_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && func == FN_PUSH && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow stack");

endmodule
